// ----- rtl/xalu_pkg.sv -----
`default_nettype none
package xalu_pkg;

    localparam int unsigned ParityBits = 8;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_ADC  = 4'd1,
        OP_SUB  = 4'd2,
        OP_SBB  = 4'd3,
        OP_AND  = 4'd4,
        OP_OR   = 4'd5,
        OP_XOR  = 4'd6,
        OP_SHL  = 4'd7,
        OP_SHR  = 4'd8,
        OP_SAR  = 4'd9,
        OP_MUL  = 4'd10,
        OP_IMUL = 4'd11,
        OP_DIV  = 4'd12,
        OP_IDIV = 4'd13,
        OP_MOD  = 4'd14,
        OP_IMOD = 4'd15
    } alu_op_t;

    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] source_value;
        logic [63:0] dest_value;
        logic [5:0]  size_bits;
    } alu_in_t;

    typedef struct packed {
        logic [63:0] result_value;
        logic        carry_out;
        logic        overflow_out;
        logic        parity_out;
        logic        zero_out;
        logic        sign_out;
        logic        divide_error;
    } alu_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture a new transaction
        logic mul_step;  // one partial product step
        logic div_start; // set up the divider
        logic div_step;  // one quotient bit
        logic finish;    // form the result and update flags
    } alu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic mul_last;
        logic div_last;
    } alu_sts_t;

endpackage
`default_nettype wire

// ----- rtl/xalu_ctrl.sv -----
`default_nettype none
module xalu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output xalu_pkg::alu_cmd_t     cmd,
    input  wire xalu_pkg::alu_sts_t sts
);
    import xalu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIVSET,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // a new transaction may enter while idle once the output register is free or is being read out
    assign in_stall  = !(state_reg == ST_IDLE && (!out_valid_reg || !out_stall));
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.is_mul)
                begin
                    state_next = ST_MUL;
                end
                else if (sts.is_div)
                begin
                    state_next = ST_DIVSET;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVSET:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/xalu_dpath.sv -----
`default_nettype none
module xalu_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire xalu_pkg::alu_in_t  in_data,
    input  wire xalu_pkg::alu_cmd_t cmd,
    output xalu_pkg::alu_sts_t      sts,
    output xalu_pkg::alu_out_t      out_data
);
    import xalu_pkg::*;

    // flags: CF OF PF ZF SF
    logic cf_reg, of_reg, pf_reg, zf_reg, sf_reg;
    logic cf_next, of_next, pf_next, zf_next, sf_next;

    logic [3:0]  op_reg;
    logic [31:0] a_reg, b_reg;
    logic [63:0] dst_reg;
    logic [5:0]  w_reg;
    logic [31:0] mask_reg;

    // multiplier: 16x32 partial products over two steps on magnitudes
    logic        mul_cnt_reg;
    logic [63:0] prod_reg;
    logic        pneg_reg;

    // divider: restoring, one bit per step on 64-bit magnitudes
    logic [63:0] quo_reg;
    logic [64:0] rem_reg;
    logic [63:0] dm_reg;
    logic [6:0]  div_cnt_reg;
    logic        qneg_reg, rneg_reg;

    alu_out_t out_reg, out_next;

    logic [5:0]  w_in;
    logic [31:0] mask_in;

    assign w_in    = (in_data.size_bits == 6'd8 || in_data.size_bits == 6'd16)
                     ? in_data.size_bits : 6'd32;
    assign mask_in = (w_in == 6'd8) ? 32'hFF : (w_in == 6'd16) ? 32'hFFFF : 32'hFFFF_FFFF;

    // sign extension to 64 bits at operand width
    function automatic logic [63:0] sext(input logic [31:0] v, input logic [5:0] w);
        logic [63:0] r;
        begin
            case (w)
                6'd8:    r = {{56{v[7]}}, v[7:0]};
                6'd16:   r = {{48{v[15]}}, v[15:0]};
                default: r = {{32{v[31]}}, v};
            endcase
            return r;
        end
    endfunction

    function automatic logic topbit(input logic [31:0] v, input logic [5:0] w);
        logic r;
        begin
            case (w)
                6'd8:    r = v[7];
                6'd16:   r = v[15];
                default: r = v[31];
            endcase
            return r;
        end
    endfunction

    logic is_mul, is_div, is_signed;
    assign is_mul    = (op_reg == OP_MUL) || (op_reg == OP_IMUL);
    assign is_div    = op_reg[3] && op_reg[2];
    assign is_signed = (op_reg == OP_IMUL) || (op_reg == OP_IDIV) || (op_reg == OP_IMOD);

    assign sts.is_mul   = is_mul;
    assign sts.is_div   = is_div;
    assign sts.mul_last = mul_cnt_reg;
    assign sts.div_last = (div_cnt_reg == 7'd63);

    // multiplier operand magnitudes
    logic        a_neg, b_neg;
    logic [31:0] a_mag, b_mag;
    logic [15:0] b_half;
    logic [47:0] pp;
    assign a_neg  = (op_reg == OP_IMUL) && topbit(a_reg, w_reg);
    assign b_neg  = (op_reg == OP_IMUL) && topbit(b_reg, w_reg);
    assign a_mag  = a_neg ? 32'(-sext(a_reg, w_reg)) : a_reg;
    assign b_mag  = b_neg ? 32'(-sext(b_reg, w_reg)) : b_reg;
    assign b_half = mul_cnt_reg ? b_mag[31:16] : b_mag[15:0];
    assign pp     = a_mag * b_half;

    // divider operands
    logic        nn, dn;
    logic [63:0] dv, nm, dmag;
    logic [64:0] rem_sh, rem_sub;
    assign nn      = (op_reg != OP_DIV) && (op_reg != OP_MOD) && dst_reg[63];
    assign dv      = is_signed ? sext(b_reg, w_reg) : {32'd0, b_reg};
    assign dn      = is_signed && dv[63];
    assign nm      = nn ? -dst_reg : dst_reg;
    assign dmag    = dn ? -dv : dv;
    assign rem_sh  = {rem_reg[63:0], quo_reg[63]};
    assign rem_sub = rem_sh - {1'b0, dm_reg};

    // non-iterative operations and final result formation
    logic [32:0] sum;
    logic        cin;
    logic [4:0]  cnt;
    logic [63:0] shl_w, sx, shr_w;
    logic [31:0] r32;
    logic [63:0] r64;
    logic        rs;
    logic [63:0] prod_s;
    logic [63:0] quo_s, rem_s;

    always_comb
    begin
        cin     = cf_reg;
        cnt     = b_reg[4:0];
        sum     = '0;
        shl_w   = '0;
        sx      = sext(a_reg, w_reg);
        shr_w   = '0;
        r32     = '0;
        r64     = '0;
        prod_s  = pneg_reg ? -prod_reg : prod_reg;
        quo_s   = qneg_reg ? -quo_reg : quo_reg;
        rem_s   = rneg_reg ? -rem_reg[63:0] : rem_reg[63:0];
        cf_next = cf_reg;
        of_next = of_reg;
        pf_next = pf_reg;
        zf_next = zf_reg;
        sf_next = sf_reg;
        out_next = out_reg;
        case (op_reg)
            OP_ADD, OP_ADC:
            begin
                sum = {1'b0, a_reg} + {1'b0, b_reg} + 33'((op_reg == OP_ADC) && cin);
                r32 = sum[31:0] & mask_reg;
                cf_next = (w_reg == 6'd8) ? sum[8] : (w_reg == 6'd16) ? sum[16] : sum[32];
                of_next = topbit((a_reg ^ r32) & (b_reg ^ r32), w_reg);
            end
            OP_SUB, OP_SBB:
            begin
                sum = {1'b0, a_reg} - {1'b0, b_reg} - 33'((op_reg == OP_SBB) && cin);
                r32 = sum[31:0] & mask_reg;
                cf_next = sum[32];
                of_next = topbit((a_reg ^ b_reg) & (a_reg ^ r32), w_reg);
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                r32 = (op_reg == OP_AND) ? (a_reg & b_reg) :
                      (op_reg == OP_OR)  ? (a_reg | b_reg) : (a_reg ^ b_reg);
                cf_next = 1'b0;
                of_next = 1'b0;
            end
            OP_SHL:
            begin
                shl_w = {32'd0, a_reg} << cnt;
                r32   = shl_w[31:0] & mask_reg;
                if (cnt != 5'd0)
                begin
                    cf_next = shl_w[w_reg];
                    of_next = topbit(r32, w_reg) ^ shl_w[w_reg];
                end
            end
            OP_SHR:
            begin
                shr_w = {a_reg, 32'd0} >> cnt;
                r32   = shr_w[63:32];
                if (cnt != 5'd0)
                begin
                    cf_next = shr_w[31];
                    of_next = topbit(a_reg, w_reg);
                end
            end
            OP_SAR:
            begin
                shr_w = $signed(sx) >>> cnt;
                r32   = shr_w[31:0] & mask_reg;
                if (cnt != 5'd0)
                begin
                    cf_next = sx[cnt - 5'd1];
                    of_next = 1'b0;
                end
            end
            OP_MUL:
            begin
                r64 = prod_reg;
                cf_next = |(prod_reg >> w_reg);
                of_next = cf_next;
            end
            OP_IMUL:
            begin
                r64 = prod_s;
                cf_next = (sext(prod_s[31:0], w_reg) != prod_s);
                of_next = cf_next;
            end
            default:
            begin
                r32 = ((op_reg == OP_DIV || op_reg == OP_IDIV) ? quo_s[31:0] : rem_s[31:0])
                      & mask_reg;
            end
        endcase
        if (!is_mul)
        begin
            r64 = {32'd0, r32};
        end
        rs = ~^r64[ParityBits-1:0];
        // flag groups left alone by some operations
        if (!is_mul && !is_div && !((op_reg == OP_SHL || op_reg == OP_SHR ||
            op_reg == OP_SAR) && cnt == 5'd0))
        begin
            pf_next = rs;
            zf_next = (r32 == 32'd0);
            sf_next = topbit(r32, w_reg);
        end
        out_next.divide_error = 1'b0;
        if (is_div && b_reg == 32'd0)
        begin
            r64 = '0;
            out_next.divide_error = 1'b1;
        end
        out_next.result_value = r64;
        out_next.carry_out    = cf_next;
        out_next.overflow_out = of_next;
        out_next.parity_out   = pf_next;
        out_next.zero_out     = zf_next;
        out_next.sign_out     = sf_next;
    end

    // flag state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cf_reg <= 1'b0;
            of_reg <= 1'b0;
            pf_reg <= 1'b0;
            zf_reg <= 1'b0;
            sf_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            cf_reg <= cf_next;
            of_reg <= of_next;
            pf_reg <= pf_next;
            zf_reg <= zf_next;
            sf_reg <= sf_next;
        end
    end

    // operand capture and iterative units
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_data.operation;
            a_reg       <= in_data.dest_value[31:0] & mask_in;
            b_reg       <= in_data.source_value & mask_in;
            dst_reg     <= in_data.dest_value;
            w_reg       <= w_in;
            mask_reg    <= mask_in;
            mul_cnt_reg <= 1'b0;
            prod_reg    <= '0;
        end
        if (cmd.mul_step)
        begin
            mul_cnt_reg <= 1'b1;
            pneg_reg    <= a_neg ^ b_neg;
            prod_reg    <= mul_cnt_reg ? prod_reg + {pp, 16'd0} : {16'd0, pp};
        end
        if (cmd.div_start)
        begin
            quo_reg     <= nm;
            rem_reg     <= '0;
            dm_reg      <= dmag;
            div_cnt_reg <= '0;
            qneg_reg    <= nn ^ dn;
            rneg_reg    <= nn;
        end
        if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 7'd1;
            if (!rem_sub[64])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

// ----- rtl/x86_integer_alu_with_flags_top.sv -----
// x86-style integer ALU with stored CF/OF/PF/ZF/SF.
// Input channel in_valid/in_stall carries an alu_in_t: operation, source,
// 64-bit destination/dividend and operand width (8, 16, else 32).
// Output channel out_valid/out_stall carries an alu_out_t: result, the
// flags after the operation and a divide-error bit.
// One transaction at a time. Steps from acceptance to out_valid:
//   add/sub/logic/shift: decode, finish
//   mul/imul: decode, two 32x16 partial-product steps, finish
//   div/idiv/mod/imod: decode, divider set-up, restoring divider one
//   quotient bit per cycle over the 64-bit dividend, finish.
// The next transaction can be taken in the cycle in which out_valid rises,
// while the previous result is taken in that same cycle, when the
// receiver does not stall.
// Reset clears the flags and empties the output register.
// While the receiver stalls a pending result, the result holds steady and
// no new transaction is accepted.
`default_nettype none
module x86_integer_alu_with_flags_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire xalu_pkg::alu_in_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output xalu_pkg::alu_out_t     out_data
);
    import xalu_pkg::*;

    alu_cmd_t cmd;
    alu_sts_t sts;

    xalu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    xalu_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // only one command phase at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_step, cmd.div_start, cmd.div_step, cmd.finish}))
        else $error("overlapping datapath commands");

    // no new transaction while a finished one is unclaimed
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(out_valid && out_stall))
        else $error("accepted over held result");

endmodule
`default_nettype wire

// ----- tb/sv/xalu_checker.sv -----
`default_nettype none
module xalu_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire xalu_pkg::alu_in_t in_data,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire xalu_pkg::alu_out_t out_data,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import xalu_pkg::*;

    // stored flags: CF, OF, PF, ZF, SF
    logic cf_q, of_q, pf_q, zf_q, sf_q;
    alu_out_t expected_results[$];

    function automatic logic [63:0] sign_extend(logic [63:0] v, int w);
        logic [63:0] m;
        m = (w == 64) ? '1 : ((64'd1 << w) - 1);
        v = v & m;
        if (v[w-1])
            v = v | ~m;
        return v;
    endfunction

    // work out one ALU transaction and update the stored flags
    function automatic alu_out_t compute_alu(alu_in_t t);
        alu_out_t o;
        int w;
        int cnt;
        logic [63:0] m, a, b, r, s, wide, sx, dv, nm, dm, q, rm, ov;
        logic cin, c, nn, dn, hi;
        w = (t.size_bits == 6'd8) ? 8 : (t.size_bits == 6'd16) ? 16 : 32;
        m = (64'd1 << w) - 1;
        a = t.dest_value & m;
        b = {32'd0, t.source_value} & m;
        cin = cf_q;
        cnt = t.source_value[4:0];
        r = 0;
        o = '0;
        case (alu_op_t'(t.operation))
            OP_ADD, OP_ADC:
            begin
                s = a + b + ((t.operation == OP_ADC) ? {63'd0, cin} : 64'd0);
                r = s & m;
                ov = (a ^ r) & (b ^ r);
                cf_q = s[w];
                of_q = ov[w-1];
            end
            OP_SUB, OP_SBB:
            begin
                c = (t.operation == OP_SBB) ? cin : 1'b0;
                r = (a - b - c) & m;
                ov = (a ^ b) & (a ^ r);
                cf_q = (b + c) > a;
                of_q = ov[w-1];
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                r = (t.operation == OP_AND) ? (a & b) :
                    (t.operation == OP_OR) ? (a | b) : (a ^ b);
                cf_q = 0;
                of_q = 0;
            end
            OP_SHL, OP_SHR, OP_SAR:
            begin
                if (cnt == 0)
                    r = a;
                else if (t.operation == OP_SHL)
                begin
                    wide = a << cnt;
                    r = wide & m;
                    cf_q = wide[w];
                    of_q = r[w-1] ^ wide[w];
                end
                else if (t.operation == OP_SHR)
                begin
                    r = a >> cnt;
                    cf_q = a[cnt-1];
                    of_q = a[w-1];
                end
                else
                begin
                    sx = sign_extend(a, w);
                    r = (sx >> cnt) & m;
                    cf_q = sx[cnt-1];
                    of_q = 0;
                end
            end
            OP_MUL:
            begin
                r = a * b;
                hi = (r >> w) != 0;
                cf_q = hi;
                of_q = hi;
            end
            OP_IMUL:
            begin
                r = sign_extend(a, w) * sign_extend(b, w);
                hi = sign_extend(r, w) != r;
                cf_q = hi;
                of_q = hi;
            end
            default:
            begin
                if (b == 0)
                    o.divide_error = 1;
                else if (t.operation == OP_DIV || t.operation == OP_MOD)
                    r = ((t.operation == OP_DIV) ? (t.dest_value / b)
                                                 : (t.dest_value % b)) & m;
                else
                begin
                    dv = sign_extend(b, w);
                    nn = t.dest_value[63];
                    dn = dv[63];
                    nm = nn ? -t.dest_value : t.dest_value;
                    dm = dn ? -dv : dv;
                    if (t.operation == OP_IDIV)
                    begin
                        q = nm / dm;
                        r = ((nn != dn) ? -q : q) & m;
                    end
                    else
                    begin
                        rm = nm % dm;
                        r = (nn ? -rm : rm) & m;
                    end
                end
            end
        endcase
        // PF/ZF/SF follow add, sub, logic and nonzero shifts
        if (t.operation <= OP_XOR ||
            (t.operation <= OP_SAR && cnt != 0))
        begin
            pf_q = ~^r[7:0];
            zf_q = (r == 0);
            sf_q = r[w-1];
        end
        o.result_value = r;
        o.carry_out = cf_q;
        o.overflow_out = of_q;
        o.parity_out = pf_q;
        o.zero_out = zf_q;
        o.sign_out = sf_q;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alu_out_t e;
        if (!rst_n)
        begin
            {cf_q, of_q, pf_q, zf_q, sf_q} = '0;
            expected_results.delete();
            fail_count <= 0;
        end
        else
        begin
            // check result before predicting: result and a new input can
            // be accepted in the same cycle, and they are different items
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_data !== e)
                    begin
                        if (out_data.result_value !== e.result_value)
                            $error("result_value exp %h got %h",
                                   e.result_value, out_data.result_value);
                        if (out_data.carry_out !== e.carry_out)
                            $error("carry_out exp %b got %b",
                                   e.carry_out, out_data.carry_out);
                        if (out_data.overflow_out !== e.overflow_out)
                            $error("overflow_out exp %b got %b",
                                   e.overflow_out, out_data.overflow_out);
                        if (out_data.parity_out !== e.parity_out)
                            $error("parity_out exp %b got %b",
                                   e.parity_out, out_data.parity_out);
                        if (out_data.zero_out !== e.zero_out)
                            $error("zero_out exp %b got %b",
                                   e.zero_out, out_data.zero_out);
                        if (out_data.sign_out !== e.sign_out)
                            $error("sign_out exp %b got %b",
                                   e.sign_out, out_data.sign_out);
                        if (out_data.divide_error !== e.divide_error)
                            $error("divide_error exp %b got %b",
                                   e.divide_error, out_data.divide_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(compute_alu(in_data));
        end
    end

    assign pending = expected_results.size();
endmodule
`default_nettype wire

// ----- tb/sv/x86_integer_alu_with_flags_top_test.sv -----
`default_nettype none
module x86_integer_alu_with_flags_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import xalu_pkg::*;

    localparam int RandomCount = 1530;
    localparam int IdleLimit = 5000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    alu_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    alu_out_t out_data;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit quiet_phase = 0;

    always #5 clk = ~clk;

    x86_integer_alu_with_flags_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    xalu_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data), .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = '1;
            2: v = v & 64'hFF;
            3: v = {v[63], 63'd0} | (v & 64'hFFFF);
            default: ;
        endcase
        return v;
    endfunction

    function automatic alu_in_t random_item();
        alu_in_t t;
        int k;
        t.operation = 4'($urandom_range(0, 15));
        t.source_value = 32'(rand64());
        if ($urandom_range(0, 3) == 0)
            t.source_value = $urandom_range(0, 40);
        t.dest_value = rand64();
        k = $urandom_range(0, 9);
        t.size_bits = (k < 3) ? 6'd8 : (k < 6) ? 6'd16 : (k < 9) ? 6'd32
                                                   : 6'($urandom_range(0, 63));
        // keep the dividend small enough that most quotients fit
        if (t.operation >= OP_DIV && $urandom_range(0, 1))
            t.dest_value = (t.operation[0] && $urandom_range(0, 1))
                ? -(rand64() & 64'hFFFF_FFFF) : (rand64() & 64'hFFFF_FFFF);
        return t;
    endfunction

    // offer one transaction, with an optional idle burst beforehand
    task automatic send_item(alu_in_t t);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // receiver stall bursts
    always @(posedge clk)
    begin
        if (quiet_phase || $urandom_range(0, 3) != 0)
            out_stall <= 0;
        else
        begin
            out_stall <= 1;
            repeat ($urandom_range(1, 11) - 1) @(posedge clk);
        end
    end

    // watchdog on cycles with no acceptance
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        alu_in_t t;
        alu_op_t op;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: every operation on extreme operands, alternating widths
        op = op.first();
        for (int i = 0; i < 16; i++)
        begin
            t.operation = op;
            t.source_value = (i % 2) ? 32'hFFFF_FFFF : 32'h8000_0001;
            t.dest_value = (i % 3 == 0) ? '1 : 64'h8000_0000_0000_0080;
            t.size_bits = (i % 3 == 0) ? 6'd8 : (i % 3 == 1) ? 6'd16 : 6'd32;
            send_item(t);
            op = op.next();
        end
        // zero shift count, zero divisor, invalid width, overwide quotient
        send_item('{OP_SHL, 32'd32, 64'h5A, 6'd8});
        send_item('{OP_SAR, 32'd20, 64'h80, 6'd8});
        send_item('{OP_DIV, 32'd0, 64'd7, 6'd16});
        send_item('{OP_IMOD, 32'h100, 64'd9, 6'd8});
        send_item('{OP_ADD, 32'hFFFF_FFFF, 64'd1, 6'd63});
        send_item('{OP_DIV, 32'd1, 64'hFFFF_FFFF_FFFF, 6'd16});
        send_item('{OP_IDIV, 32'hFF, 64'h8000_0000_0000_0000, 6'd8});
        send_item('{OP_ADC, 32'd0, 64'd0, 6'd32});
        for (int i = 0; i < RandomCount; i++)
        begin
            if (i == RandomCount - 100)
                quiet_phase = 1;
            send_item(random_item());
        end
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
